// ===== rtl/fat_cluster_sector_locator_defines.svh =====
// Assertion macros for the RTL file that checks its own logic.
`ifndef FAT_CLUSTER_SECTOR_LOCATOR_DEFINES_SVH
`define FAT_CLUSTER_SECTOR_LOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define FCSL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FCSL_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define FCSL_ASSERT(lbl, clk, rstn, prop, msg)
`define FCSL_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/fcsl_pkg.sv =====
`default_nettype none

package fcsl_pkg;

    localparam int unsigned FAT12_LIMIT = 4085;
    localparam int unsigned FAT16_LIMIT = 65525;

    localparam logic [1:0] CMD_FAT_ENTRY = 2'd0;
    localparam logic [1:0] CMD_CLUSTER   = 2'd1;
    localparam logic [1:0] CMD_ROOT      = 2'd2;

    localparam logic [1:0] TYPE_FAT12 = 2'd0;
    localparam logic [1:0] TYPE_FAT16 = 2'd1;
    localparam logic [1:0] TYPE_FAT32 = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FAT12 = 2'd1;
    localparam logic [1:0] ST_COPY  = 2'd2;

    localparam logic [2:0] REG_BPS         = 3'd0;
    localparam logic [2:0] REG_SPC         = 3'd1;
    localparam logic [2:0] REG_RESERVED    = 3'd2;
    localparam logic [2:0] REG_FAT_COPIES  = 3'd3;
    localparam logic [2:0] REG_FAT_SIZE    = 3'd4;
    localparam logic [2:0] REG_ROOT_DIR    = 3'd5;
    localparam logic [2:0] REG_TOTAL       = 3'd6;
    localparam logic [2:0] REG_ROOT_CLUSTER = 3'd7;

    typedef struct packed {
        logic [1:0]  command;
        logic [27:0] cluster;
        logic [7:0]  fat_copy;
    } t_req;

    typedef struct packed {
        logic [1:0]  vol_type;
        logic [31:0] sector;
        logic [11:0] byte_offset;
        logic [43:0] byte_address;
        logic [27:0] root_cluster_out;
        logic [1:0]  status;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/fcsl_req_if.sv =====
`default_nettype none

interface fcsl_req_if import fcsl_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/fcsl_rsp_if.sv =====
`default_nettype none

interface fcsl_rsp_if import fcsl_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/fat_cluster_sector_locator.sv =====
// A request passes the divider stages, the sum register and the output register in order.
// Throughput: one request per cycle while not settling; on a stall, stages fill bubbles.
// The FAT entry offset is divided by the sector size in four stages of eight quotient bits.
// Reset is synchronous: valid flags clear and the geometry registers take their defaults.
// After reset and after every register write, requests wait on a settle counter while the
// derived geometry (FAT type, data start, root sector) settles through its registers.
`default_nettype none
`include "fat_cluster_sector_locator_defines.svh"

module fat_cluster_sector_locator import fcsl_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    fcsl_req_if.sink    i_req,
    fcsl_rsp_if.source  o_rsp,
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_idx,
    input  wire [31:0]  i_cfg_data
);

    localparam int DIV_STEPS  = 8;
    localparam int DIV_STAGES = 4;
    localparam logic [2:0] SETTLE_CYCLES = 3'd4;

    typedef struct packed {
        logic [12:0] rem;
        logic [31:0] num;
        logic [31:0] quo;
    } t_div;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  status;
        logic        ok;
        t_div        div;
        logic [31:0] prod_copy;
        logic [31:0] prod_clus;
    } t_stage;

    typedef struct packed {
        logic [1:0]  status;
        logic        ok;
        logic [12:0] rem;
        logic [31:0] sector;
        logic [27:0] rclus;
    } t_sum;

    function automatic t_div div_step8(input t_div d_in, input logic [12:0] divisor);
        t_div        d;
        logic [13:0] t;
        d = d_in;
        for (int i = 0; i < DIV_STEPS; i++) begin
            t = {d.rem, d.num[31]};
            d.num = {d.num[30:0], 1'b0};
            if (t >= {1'b0, divisor}) begin
                d.rem = 13'(t - {1'b0, divisor});
                d.quo = {d.quo[30:0], 1'b1};
            end else begin
                d.rem = t[12:0];
                d.quo = {d.quo[30:0], 1'b0};
            end
        end
        return d;
    endfunction

    // Geometry registers.
    logic [12:0] r_bps;
    logic [7:0]  r_spc;
    logic [15:0] r_reserved;
    logic [7:0]  r_fat_copies;
    logic [31:0] r_fat_size;
    logic [15:0] r_root_dir;
    logic [31:0] r_total;
    logic [27:0] r_root_cluster;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps          <= 13'd512;
            r_spc          <= 8'd1;
            r_reserved     <= 16'd32;
            r_fat_copies   <= 8'd2;
            r_fat_size     <= 32'd0;
            r_root_dir     <= 16'd0;
            r_total        <= 32'd0;
            r_root_cluster <= 28'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BPS:          r_bps          <= i_cfg_data[12:0];
                REG_SPC:          r_spc          <= i_cfg_data[7:0];
                REG_RESERVED:     r_reserved     <= i_cfg_data[15:0];
                REG_FAT_COPIES:   r_fat_copies   <= i_cfg_data[7:0];
                REG_FAT_SIZE:     r_fat_size     <= i_cfg_data;
                REG_ROOT_DIR:     r_root_dir     <= i_cfg_data[15:0];
                REG_TOTAL:        r_total        <= i_cfg_data;
                REG_ROOT_CLUSTER: r_root_cluster <= i_cfg_data[27:0];
                default: begin
                end
            endcase
        end
    end

    logic [2:0] r_settle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_settle <= SETTLE_CYCLES;
        end else if (r_settle != 3'd0) begin
            r_settle <= r_settle - 3'd1;
        end
    end

    // Derived geometry, recomputed every cycle from the registers.
    logic [12:0] r_bps_eff;
    logic [7:0]  r_spc_eff;
    logic [31:0] r_fat_area;
    logic [19:0] r_lim12;
    logic [23:0] r_lim16;
    logic [31:0] r_fat_end;
    logic [31:0] r_first_data;
    logic [31:0] r_root_mul;
    logic [31:0] r_data_sec;
    logic [31:0] r_root_sector;
    logic [1:0]  r_type;

    always_ff @(posedge i_clk) begin
        r_bps_eff     <= (r_bps == 13'd0) ? 13'd1 : r_bps;
        r_spc_eff     <= (r_spc == 8'd0) ? 8'd1 : r_spc;
        r_fat_area    <= r_fat_size * {24'd0, r_fat_copies};
        r_lim12       <= 20'(FAT12_LIMIT * 32'(r_spc_eff));
        r_lim16       <= 24'(FAT16_LIMIT * 32'(r_spc_eff));
        r_fat_end     <= {16'd0, r_reserved} + r_fat_area;
        r_first_data  <= {16'd0, r_reserved} + r_fat_area + {16'd0, r_root_dir};
        r_root_mul    <= ({4'd0, r_root_cluster} - 32'd2) * {24'd0, r_spc_eff};
        r_data_sec    <= r_total - r_first_data;
        r_root_sector <= r_root_mul + r_first_data;
        if (r_data_sec < {12'd0, r_lim12}) begin
            r_type <= TYPE_FAT12;
        end else if (r_data_sec < {8'd0, r_lim16}) begin
            r_type <= TYPE_FAT16;
        end else begin
            r_type <= TYPE_FAT32;
        end
    end

    // Request pipeline.
    logic [DIV_STAGES-1:0] r_v;
    t_stage                r_st [DIV_STAGES];
    logic                  r_v5;
    t_sum                  r_s5;
    logic                  r_ov;
    t_rsp                  r_out;

    logic [DIV_STAGES-1:0] rdy_st;
    logic                  rdy5;
    logic                  rdy_out;
    logic                  in_xfer;

    assign rdy_out = !r_ov || o_rsp.ready;
    assign rdy5    = !r_v5 || rdy_out;
    assign rdy_st[DIV_STAGES-1] = !r_v[DIV_STAGES-1] || rdy5;

    for (genvar g = 0; g < DIV_STAGES - 1; g++) begin : g_rdy
        assign rdy_st[g] = !r_v[g] || rdy_st[g+1];
    end

    assign i_req.ready = rdy_st[0] && (r_settle == 3'd0);
    assign in_xfer     = i_req.valid && i_req.ready;

    t_stage n_st0;
    t_div   n_div0;

    always_comb begin
        n_st0           = '0;
        n_st0.cmd       = i_req.payload.command;
        n_st0.status    = ST_OK;
        n_st0.ok        = 1'b0;
        n_st0.prod_copy = r_fat_size * {24'd0, i_req.payload.fat_copy};
        n_st0.prod_clus = ({4'd0, i_req.payload.cluster} - 32'd2) * {24'd0, r_spc_eff};
        n_div0          = '0;
        if (r_type == TYPE_FAT16) begin
            n_div0.num = {3'd0, i_req.payload.cluster, 1'b0};
        end else begin
            n_div0.num = {2'd0, i_req.payload.cluster, 2'd0};
        end
        n_st0.div = div_step8(n_div0, r_bps_eff);
        case (i_req.payload.command)
            CMD_FAT_ENTRY: begin
                if (r_type == TYPE_FAT12) begin
                    n_st0.status = ST_FAT12;
                end else if (i_req.payload.fat_copy >= r_fat_copies) begin
                    n_st0.status = ST_COPY;
                end else begin
                    n_st0.ok = 1'b1;
                end
            end
            CMD_CLUSTER: begin
                n_st0.ok = 1'b1;
            end
            CMD_ROOT: begin
                if (r_type == TYPE_FAT12) begin
                    n_st0.status = ST_FAT12;
                end else begin
                    n_st0.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (rdy_st[0]) begin
            r_v[0] <= in_xfer;
        end
        if (in_xfer) begin
            r_st[0] <= n_st0;
        end
    end

    for (genvar g = 1; g < DIV_STAGES; g++) begin : g_div
        t_stage n_st;

        always_comb begin
            n_st     = r_st[g-1];
            n_st.div = div_step8(r_st[g-1].div, r_bps_eff);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (rdy_st[g]) begin
                r_v[g] <= r_v[g-1];
            end
            if (rdy_st[g] && r_v[g-1]) begin
                r_st[g] <= n_st;
            end
        end
    end

    t_sum   n_s5;
    t_stage last_st;

    assign last_st = r_st[DIV_STAGES-1];

    always_comb begin
        n_s5        = '0;
        n_s5.status = last_st.status;
        n_s5.ok     = last_st.ok;
        if (last_st.ok) begin
            case (last_st.cmd)
                CMD_FAT_ENTRY: begin
                    n_s5.sector = last_st.prod_copy + {16'd0, r_reserved} + last_st.div.quo;
                    n_s5.rem    = last_st.div.rem;
                end
                CMD_CLUSTER: begin
                    n_s5.sector = last_st.prod_clus + r_first_data;
                end
                CMD_ROOT: begin
                    if (r_type == TYPE_FAT16) begin
                        n_s5.sector = r_fat_end;
                    end else begin
                        n_s5.sector = r_root_sector;
                        n_s5.rclus  = r_root_cluster;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (rdy5) begin
            r_v5 <= r_v[DIV_STAGES-1];
        end
        if (rdy5 && r_v[DIV_STAGES-1]) begin
            r_s5 <= n_s5;
        end
    end

    logic [44:0] byte_addr_full;
    t_rsp        n_out;

    assign byte_addr_full = 45'(r_s5.sector) * 45'(r_bps_eff) + 45'(r_s5.rem);

    always_comb begin
        n_out.vol_type         = r_type;
        n_out.sector           = r_s5.sector;
        n_out.byte_offset      = r_s5.rem[11:0];
        n_out.byte_address     = r_s5.ok ? byte_addr_full[43:0] : 44'd0;
        n_out.root_cluster_out = r_s5.rclus;
        n_out.status           = r_s5.status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (rdy_out) begin
            r_ov <= r_v5;
        end
        if (rdy_out && r_v5) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid   = r_ov;
    assign o_rsp.payload = r_out;

    `FCSL_ASSERT(a_settle_after_write, i_clk, i_rst_n, i_cfg_we |-> ##4 !(i_req.valid && i_req.ready), "request taken before derived geometry settled")
    `FCSL_ASSERT_IMPLY(a_error_zero, i_clk, i_rst_n, o_rsp.valid && (o_rsp.payload.status != ST_OK), (o_rsp.payload.sector == 32'd0) && (o_rsp.payload.byte_address == 44'd0), "error response carries an address")
    `FCSL_ASSERT_IMPLY(a_root_fat32, i_clk, i_rst_n, o_rsp.valid && (o_rsp.payload.root_cluster_out != 28'd0), (o_rsp.payload.vol_type == TYPE_FAT32) && (o_rsp.payload.status == ST_OK), "root cluster given outside FAT32")

endmodule

`default_nettype wire

// ===== verif/fat_cluster_sector_locator_tb.sv =====
module fat_cluster_sector_locator_tb;
    import fcsl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int REG_BITS [8] = '{13, 8, 16, 8, 32, 16, 32, 28};
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASES = 24;
    localparam int ITEMS_PER_PHASE = 80;

    typedef enum logic [1:0] {ROW_WRITE, ROW_ITEM, ROW_KNOWN} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [31:0] data;
        t_req        rq;
        t_rsp        want;
    } t_row;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;

    fcsl_req_if req_bus ();
    fcsl_rsp_if rsp_bus ();

    logic [31:0] geo [8];
    t_rsp        pending_rsp [$];
    t_row        plan [$];
    bit          idle_on;
    int          rsp_stall;
    int          errors;
    int          items_sent;
    int          rsp_seen;
    int          rsp_by_type [4];
    int          geometries;

    fat_cluster_sector_locator uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] reg_mask(input logic [2:0] idx);
        if (REG_BITS[idx] >= 32) begin
            return 32'hFFFF_FFFF;
        end
        return (32'd1 << REG_BITS[idx]) - 32'd1;
    endfunction

    function automatic t_rsp locate_sector(input t_req rq);
        logic [31:0] bps;
        logic [31:0] spc;
        logic [31:0] fat_area;
        logic [31:0] first_data;
        logic [31:0] clusters;
        logic [31:0] fat_off;
        logic [31:0] clus32;
        logic [31:0] sect;
        logic [31:0] offs;
        logic [31:0] rclus;
        logic [63:0] addr;
        logic [1:0]  ftype;
        logic [1:0]  st;
        logic        located;
        t_rsp        r;
        bps = (geo[REG_BPS] == 32'd0) ? 32'd1 : geo[REG_BPS];
        spc = (geo[REG_SPC] == 32'd0) ? 32'd1 : geo[REG_SPC];
        fat_area = geo[REG_FAT_COPIES] * geo[REG_FAT_SIZE];
        first_data = geo[REG_RESERVED] + fat_area + geo[REG_ROOT_DIR];
        clusters = (geo[REG_TOTAL] - first_data) / spc;
        if (clusters < FAT12_LIMIT) begin
            ftype = TYPE_FAT12;
        end else if (clusters < FAT16_LIMIT) begin
            ftype = TYPE_FAT16;
        end else begin
            ftype = TYPE_FAT32;
        end
        clus32 = {4'd0, rq.cluster};
        sect = '0;
        offs = '0;
        rclus = '0;
        st = ST_OK;
        located = 1'b0;
        case (rq.command)
            CMD_FAT_ENTRY: begin
                if (ftype == TYPE_FAT12) begin
                    st = ST_FAT12;
                end else if ({24'd0, rq.fat_copy} >= geo[REG_FAT_COPIES]) begin
                    st = ST_COPY;
                end else begin
                    fat_off = (ftype == TYPE_FAT16) ? (clus32 << 1) : (clus32 << 2);
                    sect = {24'd0, rq.fat_copy} * geo[REG_FAT_SIZE] + geo[REG_RESERVED]
                         + fat_off / bps;
                    offs = fat_off % bps;
                    located = 1'b1;
                end
            end
            CMD_CLUSTER: begin
                sect = (clus32 - 32'd2) * spc + first_data;
                located = 1'b1;
            end
            CMD_ROOT: begin
                if (ftype == TYPE_FAT12) begin
                    st = ST_FAT12;
                end else if (ftype == TYPE_FAT16) begin
                    sect = geo[REG_RESERVED] + fat_area;
                    located = 1'b1;
                end else begin
                    rclus = geo[REG_ROOT_CLUSTER];
                    sect = (rclus - 32'd2) * spc + first_data;
                    located = 1'b1;
                end
            end
            default: begin
            end
        endcase
        addr = {32'd0, sect} * {32'd0, bps} + {32'd0, offs};
        r.vol_type = ftype;
        r.sector = sect;
        r.byte_offset = offs[11:0];
        r.byte_address = located ? addr[43:0] : 44'd0;
        r.root_cluster_out = rclus[27:0];
        r.status = st;
        return r;
    endfunction

    task automatic add_write(input logic [2:0] idx, input logic [31:0] data);
        t_row row;
        row = '0;
        row.kind = ROW_WRITE;
        row.idx = idx;
        row.data = data;
        plan.push_back(row);
    endtask

    task automatic add_item(input logic [1:0] cmd, input logic [27:0] clus,
                            input logic [7:0] copy);
        t_row row;
        row = '0;
        row.kind = ROW_ITEM;
        row.rq.command = cmd;
        row.rq.cluster = clus;
        row.rq.fat_copy = copy;
        plan.push_back(row);
    endtask

    task automatic add_known(input logic [1:0] cmd, input logic [27:0] clus,
                             input logic [7:0] copy, input logic [1:0] ftype,
                             input logic [31:0] sect, input logic [11:0] offs,
                             input logic [43:0] addr, input logic [27:0] rclus,
                             input logic [1:0] st);
        t_row row;
        row.kind = ROW_KNOWN;
        row.idx = '0;
        row.data = '0;
        row.rq.command = cmd;
        row.rq.cluster = clus;
        row.rq.fat_copy = copy;
        row.want.vol_type = ftype;
        row.want.sector = sect;
        row.want.byte_offset = offs;
        row.want.byte_address = addr;
        row.want.root_cluster_out = rclus;
        row.want.status = st;
        plan.push_back(row);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge clk);
        geo[idx] = data & reg_mask(idx);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle_idle();
        req_bus.valid <= 1'b0;
        while (pending_rsp.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic push_req(input t_req rq, input bit known, input t_rsp want);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.payload <= rq;
        do begin
            @(posedge clk);
        end while (!req_bus.ready);
        pending_rsp.push_back(known ? want : locate_sector(rq));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    initial begin
        rsp_bus.ready = 1'b0;
        rsp_stall = 0;
        forever begin
            @(negedge clk);
            if (rsp_stall != 0) begin
                rsp_bus.ready <= 1'b0;
                rsp_stall--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                rsp_bus.ready <= 1'b0;
                rsp_stall = $urandom_range(0, 10);
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : rsp_check
        t_rsp want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_rsp.size() == 0) begin
                $error("response transfer with no request outstanding");
                errors++;
            end else begin
                want = pending_rsp.pop_front();
                check_field("vol_type", want.vol_type, rsp_bus.payload.vol_type);
                check_field("sector", want.sector, rsp_bus.payload.sector);
                check_field("byte_offset", want.byte_offset, rsp_bus.payload.byte_offset);
                check_field("byte_address", want.byte_address,
                            rsp_bus.payload.byte_address);
                check_field("root_cluster_out", want.root_cluster_out,
                            rsp_bus.payload.root_cluster_out);
                check_field("status", want.status, rsp_bus.payload.status);
                rsp_by_type[rsp_bus.payload.vol_type]++;
                rsp_seen++;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [31:0] vals [8];
        logic [31:0] ovh;
        logic [31:0] spe;
        logic [31:0] cnt;
        t_req        rq;
        bit          after_item;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        req_bus.valid = 1'b0;
        req_bus.payload = '0;
        idle_on = 1'b1;
        geo = '{32'd512, 32'd1, 32'd32, 32'd2, 32'd0, 32'd0, 32'd0, 32'd2};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_known(CMD_FAT_ENTRY, 28'd0, 8'd0, TYPE_FAT32, 32'd32, 12'd0, 44'd16384,
                  28'd0, ST_OK);
        add_known(CMD_FAT_ENTRY, 28'hFFF_FFFF, 8'd1, TYPE_FAT32, 32'h0020_001F, 12'd508,
                  44'h0_4000_3FFC, 28'd0, ST_OK);
        add_known(CMD_FAT_ENTRY, 28'd5, 8'd2, TYPE_FAT32, 32'd0, 12'd0, 44'd0, 28'd0,
                  ST_COPY);
        add_known(CMD_FAT_ENTRY, 28'hFFF_FFFF, 8'hFF, TYPE_FAT32, 32'd0, 12'd0, 44'd0,
                  28'd0, ST_COPY);
        add_known(CMD_CLUSTER, 28'd0, 8'd0, TYPE_FAT32, 32'd30, 12'd0, 44'd15360,
                  28'd0, ST_OK);
        add_known(CMD_CLUSTER, 28'hFFF_FFFF, 8'd0, TYPE_FAT32, 32'h1000_001D, 12'd0,
                  44'h20_0000_3A00, 28'd0, ST_OK);
        add_known(CMD_ROOT, 28'd0, 8'd0, TYPE_FAT32, 32'd32, 12'd0, 44'd16384, 28'd2,
                  ST_OK);
        add_known(CMD_UNUSED, 28'hFFF_FFFF, 8'hFF, TYPE_FAT32, 32'd0, 12'd0, 44'd0,
                  28'd0, ST_OK);
        add_write(REG_TOTAL, 32'd1000);
        add_known(CMD_FAT_ENTRY, 28'd7, 8'd0, TYPE_FAT12, 32'd0, 12'd0, 44'd0, 28'd0,
                  ST_FAT12);
        add_known(CMD_FAT_ENTRY, 28'd7, 8'hFF, TYPE_FAT12, 32'd0, 12'd0, 44'd0, 28'd0,
                  ST_FAT12);
        add_known(CMD_ROOT, 28'd0, 8'd0, TYPE_FAT12, 32'd0, 12'd0, 44'd0, 28'd0, ST_FAT12);
        add_known(CMD_CLUSTER, 28'd2, 8'd0, TYPE_FAT12, 32'd32, 12'd0, 44'd16384, 28'd0,
                  ST_OK);
        add_known(CMD_UNUSED, 28'd0, 8'd0, TYPE_FAT12, 32'd0, 12'd0, 44'd0, 28'd0, ST_OK);
        add_write(REG_FAT_SIZE, 32'd16);
        add_write(REG_ROOT_DIR, 32'd32);
        add_write(REG_TOTAL, 32'd4181);
        add_known(CMD_ROOT, 28'd0, 8'd0, TYPE_FAT16, 32'd64, 12'd0, 44'd32768, 28'd0,
                  ST_OK);
        add_known(CMD_FAT_ENTRY, 28'd300, 8'd1, TYPE_FAT16, 32'd49, 12'd88, 44'd25176,
                  28'd0, ST_OK);
        add_known(CMD_CLUSTER, 28'd2, 8'd0, TYPE_FAT16, 32'd96, 12'd0, 44'd49152, 28'd0,
                  ST_OK);
        add_write(REG_TOTAL, 32'd4180);
        add_known(CMD_ROOT, 28'd0, 8'd0, TYPE_FAT12, 32'd0, 12'd0, 44'd0, 28'd0, ST_FAT12);
        add_write(REG_TOTAL, 32'd65620);
        add_known(CMD_ROOT, 28'd0, 8'd0, TYPE_FAT16, 32'd64, 12'd0, 44'd32768, 28'd0,
                  ST_OK);
        add_write(REG_TOTAL, 32'd65621);
        add_known(CMD_ROOT, 28'd0, 8'd0, TYPE_FAT32, 32'd96, 12'd0, 44'd49152, 28'd2,
                  ST_OK);
        add_known(CMD_FAT_ENTRY, 28'd0, 8'd1, TYPE_FAT32, 32'd48, 12'd0, 44'd24576, 28'd0,
                  ST_OK);
        add_write(REG_BPS, 32'd0);
        add_known(CMD_FAT_ENTRY, 28'd3, 8'd0, TYPE_FAT32, 32'd44, 12'd0, 44'd44, 28'd0,
                  ST_OK);
        add_known(CMD_CLUSTER, 28'd2, 8'd0, TYPE_FAT32, 32'd96, 12'd0, 44'd96, 28'd0,
                  ST_OK);
        add_write(REG_BPS, 32'd8191);
        add_known(CMD_FAT_ENTRY, 28'd1500, 8'd1, TYPE_FAT32, 32'd48, 12'd1904,
                  44'd399168, 28'd0, ST_OK);
        add_write(REG_SPC, 32'd0);
        add_item(CMD_CLUSTER, 28'd0, 8'd0);
        add_item(CMD_ROOT, 28'd0, 8'd0);
        add_write(REG_ROOT_CLUSTER, 32'h0FFF_FFFF);
        add_item(CMD_ROOT, 28'd0, 8'd0);
        add_write(REG_FAT_COPIES, 32'd1);
        add_write(REG_RESERVED, 32'd65535);
        add_item(CMD_FAT_ENTRY, 28'd9, 8'd1);

        after_item = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                if (after_item) begin
                    settle_idle();
                end
                after_item = 1'b0;
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                push_req(plan[i].rq, plan[i].kind == ROW_KNOWN, plan[i].want);
                after_item = 1'b1;
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle_idle();
            idle_on = (p < PHASES - 4) && (p % 6 != 3);
            if (p == 0) begin
                foreach (vals[r]) vals[r] = 32'hFFFF_FFFF;
            end else if (p == 1) begin
                foreach (vals[r]) vals[r] = 32'd0;
            end else begin
                case ($urandom_range(0, 7))
                    0: vals[REG_BPS] = 32'd512;
                    1: vals[REG_BPS] = 32'd1024;
                    2: vals[REG_BPS] = 32'd2048;
                    3: vals[REG_BPS] = 32'd4096;
                    4: vals[REG_BPS] = 32'd0;
                    5: vals[REG_BPS] = 32'd8191;
                    default: vals[REG_BPS] = $urandom_range(1, 8191);
                endcase
                case ($urandom_range(0, 5))
                    0: vals[REG_SPC] = 32'd0;
                    1: vals[REG_SPC] = 32'd255;
                    2: vals[REG_SPC] = $urandom_range(0, 255);
                    default: vals[REG_SPC] = 32'd1 << $urandom_range(0, 7);
                endcase
                vals[REG_RESERVED] = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                                : $urandom_range(0, 64);
                vals[REG_FAT_COPIES] = $urandom_range(0, 4) == 0 ? $urandom_range(0, 255)
                                                                  : $urandom_range(1, 4);
                vals[REG_FAT_SIZE] = $urandom_range(0, 4) == 0 ? $urandom()
                                                                : $urandom_range(0, 8192);
                case ($urandom_range(0, 2))
                    0: vals[REG_ROOT_DIR] = 32'd0;
                    1: vals[REG_ROOT_DIR] = $urandom_range(0, 1024);
                    default: vals[REG_ROOT_DIR] = $urandom_range(0, 65535);
                endcase
                vals[REG_ROOT_CLUSTER] = $urandom_range(0, 2) == 0 ? 32'd2
                                                                    : ($urandom() & 32'h0FFF_FFFF);
                ovh = vals[REG_RESERVED] + vals[REG_FAT_COPIES] * vals[REG_FAT_SIZE]
                    + vals[REG_ROOT_DIR];
                spe = (vals[REG_SPC] == 32'd0) ? 32'd1 : vals[REG_SPC];
                case ($urandom_range(0, 6))
                    0: cnt = $urandom_range(0, 4084);
                    1: cnt = 32'd4084 + $urandom_range(0, 1);
                    2: cnt = $urandom_range(4086, 65524);
                    3: cnt = 32'd65524 + $urandom_range(0, 1);
                    default: cnt = $urandom_range(65526, 32'hFFFF_FFFF / spe - 32'd1);
                endcase
                vals[REG_TOTAL] = ovh + cnt * spe + $urandom_range(0, spe - 32'd1);
                if ($urandom_range(0, 9) == 0) begin
                    vals[REG_TOTAL] = $urandom();
                end
                foreach (vals[r]) begin
                    if ($urandom_range(0, 3) == 0) begin
                        vals[r] = vals[r] | ($urandom() & ~reg_mask(r[2:0]));
                    end
                end
            end
            for (int r = 0; r < 8; r++) begin
                write_reg(r[2:0], vals[r]);
            end
            geometries++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: rq.command = CMD_FAT_ENTRY;
                    4, 5, 6: rq.command = CMD_CLUSTER;
                    7, 8: rq.command = CMD_ROOT;
                    default: rq.command = CMD_UNUSED;
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: rq.cluster = 28'($urandom());
                    5, 6, 7: rq.cluster = 28'($urandom_range(0, 70000));
                    8: rq.cluster = 28'($urandom_range(0, 3));
                    default: rq.cluster = 28'hFFF_FFFF - 28'($urandom_range(0, 3));
                endcase
                if (geo[REG_FAT_COPIES] != 32'd0 && $urandom_range(0, 4) != 0) begin
                    rq.fat_copy = 8'($urandom_range(0, geo[REG_FAT_COPIES] - 32'd1));
                end else begin
                    rq.fat_copy = 8'($urandom_range(0, 255));
                end
                push_req(rq, 1'b0, '0);
            end
        end

        settle_idle();
        $display("Checked %0d responses to %0d requests over %0d random geometries.",
                 rsp_seen, items_sent, geometries);
        $display("Responses by derived type: FAT12 %0d, FAT16 %0d, FAT32 %0d.",
                 rsp_by_type[TYPE_FAT12], rsp_by_type[TYPE_FAT16], rsp_by_type[TYPE_FAT32]);
        if (errors == 0 && pending_rsp.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
